// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int BUCKETS_DEF = 128;
  localparam int NODES_DEF   = 64;
  localparam int KEY_W       = 16;
  localparam int VH_W        = 64;
  localparam int VT_W        = 8;
  localparam int CNT_OUT_W   = 7;
  localparam int KEY3_W      = KEY_W + 2;
  localparam int MOD_STEPS   = 2;
  localparam int MC_W        = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    ACT_PUT = 2'd0,
    ACT_GET = 2'd1,
    ACT_REM = 2'd2,
    ACT_CLR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_UPD  = 3'd1,
    ST_MISS = 3'd2,
    ST_FULL = 3'd3,
    ST_CLR  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_MOD,
    S_BRD,
    S_HEAD,
    S_NCHK,
    S_HIT,
    S_MISS,
    S_CLRFIN
  } state_t;

  typedef struct packed {
    logic    load;
    logic    mod_step;
    logic    bkt_rd;
    logic    head_load;
    logic    walk_adv;
    logic    put_upd;
    logic    put_ins;
    logic    rem_hit;
    logic    sweep_wr;
    logic    res_load;
    status_t res_status;
    logic    res_found;
    logic    res_value;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    mod_last;
    logic    head_nil;
    logic    key_match;
    logic    next_nil;
    logic    pool_full;
    logic    sweep_last;
    logic    out_busy;
  } sts_t;

endpackage

// ===== rtl/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// Request sequencer: bucket hash, chain walk, outcome and clearing pass.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_action,
  output logic            in_ready,
  input  cht_pkg::sts_t   sts,
  output cht_pkg::cmd_t   cmd
);
  import cht_pkg::*;

  state_t state_r, state_nxt;
  logic   clr_pend_r, clr_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_pend_nxt = clr_pend_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = clr_pend_r ? S_CLRFIN : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action_t'(in_action) == ACT_CLR) begin
            state_nxt    = S_SWEEP;
            clr_pend_nxt = 1'b1;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (sts.mod_last) state_nxt = S_BRD;
      end
      S_BRD: state_nxt = S_HEAD;
      S_HEAD: state_nxt = sts.head_nil ? S_MISS : S_NCHK;
      S_NCHK: begin
        if (sts.key_match) state_nxt = S_HIT;
        else if (sts.next_nil) state_nxt = S_MISS;
      end
      S_HIT, S_MISS: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      S_CLRFIN: begin
        if (!sts.out_busy) begin
          state_nxt    = S_IDLE;
          clr_pend_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_SWEEP: cmd.sweep_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MOD: cmd.mod_step = 1'b1;
      S_BRD: cmd.bkt_rd = 1'b1;
      S_HEAD: cmd.head_load = !sts.head_nil;
      S_NCHK: cmd.walk_adv = !sts.key_match && !sts.next_nil;
      S_HIT: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          case (sts.act)
            ACT_PUT: begin
              cmd.put_upd    = 1'b1;
              cmd.res_status = ST_UPD;
            end
            ACT_GET: begin
              cmd.res_found = 1'b1;
              cmd.res_value = 1'b1;
            end
            ACT_REM: begin
              cmd.rem_hit   = 1'b1;
              cmd.res_found = 1'b1;
            end
            default: cmd.res_status = ST_CLR;
          endcase
        end
      end
      S_MISS: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          if (sts.act == ACT_PUT) begin
            if (sts.pool_full) cmd.res_status = ST_FULL;
            else cmd.put_ins = 1'b1;
          end else begin
            cmd.res_status = ST_MISS;
          end
        end
      end
      S_CLRFIN: begin
        if (!sts.out_busy) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CLR;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/cht_dp.sv =====
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: bucket hash by reciprocal multiply, bucket and node memories,
// free stack, entry count and result register.
// ----------------------------------------------------------------------------
module cht_dp #(
  parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
  parameter int NODES   = cht_pkg::NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_action,
  input  logic [cht_pkg::KEY_W-1:0]       in_key_in,
  input  logic [cht_pkg::VH_W-1:0]        in_value_head,
  input  logic [cht_pkg::VT_W-1:0]        in_value_tail,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [2:0]                      out_status,
  output logic                            out_found,
  output logic [cht_pkg::VH_W-1:0]        out_value_head_out,
  output logic [cht_pkg::VT_W-1:0]        out_value_tail_out,
  output logic [cht_pkg::CNT_OUT_W-1:0]   out_entry_count,
  input  cht_pkg::cmd_t                   cmd,
  output cht_pkg::sts_t                   sts
);
  import cht_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int NA = $clog2(NODES);
  localparam int NW = $clog2(NODES + 1);
  localparam int VW = VH_W + VT_W;
  localparam int SH = KEY3_W + BW;
  localparam longint RECIP_L =
    ((longint'(1) <<< SH) + longint'(BUCKETS) - 1) / longint'(BUCKETS);
  localparam int RW = $clog2(RECIP_L + 1);
  localparam logic [RW-1:0]     RECIP   = RW'(RECIP_L);
  localparam logic [KEY3_W-1:0] BK      = KEY3_W'(BUCKETS);
  localparam logic [NW-1:0]     NIL     = NW'(NODES);
  localparam logic [BW-1:0]     BLAST   = BW'(BUCKETS - 1);
  localparam logic [MC_W-1:0]   MC_LAST = MC_W'(MOD_STEPS - 1);

  action_t           act_r;
  logic [KEY_W-1:0]  key_r;
  logic [VW-1:0]     val_r;

  logic [KEY3_W-1:0]    k3_r;
  logic [KEY3_W-1:0]    q_r;
  logic [BW-1:0]        rem_r;
  logic [MC_W-1:0]      mc_r;
  logic [KEY3_W+RW-1:0] prod_w;
  logic [KEY3_W-1:0]    rem_w;

  logic [BW-1:0]     sweep_r;

  logic [NW-1:0]     bkt_mem [BUCKETS];
  logic [NW-1:0]     head_r;
  logic              bwr_en;
  logic [BW-1:0]     bwr_addr;
  logic [NW-1:0]     bwr_data;

  logic [KEY_W-1:0]  key_mem [NODES];
  logic [VW-1:0]     val_mem [NODES];
  logic [NW-1:0]     nxt_mem [NODES];
  logic [KEY_W-1:0]  d_key_r;
  logic [VW-1:0]     d_val_r;
  logic [NW-1:0]     d_nxt_r;
  logic [NW-1:0]     cur_r;
  logic [NW-1:0]     prev_r;
  logic              prev_valid_r;
  logic [KEY_W-1:0]  p_key_r;
  logic [VW-1:0]     p_val_r;
  logic              nrd_en;
  logic [NW-1:0]     nrd_addr;
  logic              nwr_en;
  logic [NW-1:0]     nwr_addr;
  logic [KEY_W-1:0]  nwr_key;
  logic [VW-1:0]     nwr_val;
  logic [NW-1:0]     nwr_nxt;

  logic [NA-1:0]     stk_mem [NODES];
  logic [NA-1:0]     stk_top_r;
  logic [NW-1:0]     sp_r;
  logic [NW-1:0]     fresh_r;
  logic [NW-1:0]     count_r, count_nxt;
  logic [NW-1:0]     free_node;

  logic              out_valid_r;

  assign prod_w    = k3_r * RECIP;
  assign rem_w     = k3_r - q_r * BK;
  assign free_node = (sp_r != '0) ? NW'(stk_top_r) : fresh_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_action);
      key_r <= in_key_in;
      val_r <= {in_value_head, in_value_tail};
      k3_r  <= {2'b00, in_key_in} + {1'b0, in_key_in, 1'b0};
      mc_r  <= '0;
    end else if (cmd.mod_step) begin
      if (mc_r == MC_LAST) rem_r <= BW'(rem_w);
      else q_r <= KEY3_W'(prod_w >> SH);
      mc_r <= mc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= (sweep_r == BLAST) ? '0 : sweep_r + 1'b1;
    end
  end

  always_comb begin
    bwr_en   = 1'b0;
    bwr_addr = rem_r;
    bwr_data = NIL;
    if (cmd.sweep_wr) begin
      bwr_en   = 1'b1;
      bwr_addr = sweep_r;
    end else if (cmd.put_ins) begin
      bwr_en   = 1'b1;
      bwr_data = free_node;
    end else if (cmd.rem_hit && !prev_valid_r) begin
      bwr_en   = 1'b1;
      bwr_data = d_nxt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bwr_en) bkt_mem[bwr_addr] <= bwr_data;
    if (cmd.bkt_rd) head_r <= bkt_mem[rem_r];
  end

  assign nrd_en   = cmd.head_load || cmd.walk_adv;
  assign nrd_addr = cmd.head_load ? head_r : d_nxt_r;

  always_comb begin
    nwr_en   = 1'b0;
    nwr_addr = cur_r;
    nwr_key  = key_r;
    nwr_val  = val_r;
    nwr_nxt  = d_nxt_r;
    if (cmd.put_upd) begin
      nwr_en = 1'b1;
    end else if (cmd.put_ins) begin
      nwr_en   = 1'b1;
      nwr_addr = free_node;
      nwr_nxt  = head_r;
    end else if (cmd.rem_hit && prev_valid_r) begin
      nwr_en   = 1'b1;
      nwr_addr = prev_r;
      nwr_key  = p_key_r;
      nwr_val  = p_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nwr_en) begin
      key_mem[nwr_addr[NA-1:0]] <= nwr_key;
      val_mem[nwr_addr[NA-1:0]] <= nwr_val;
      nxt_mem[nwr_addr[NA-1:0]] <= nwr_nxt;
    end
    if (nrd_en) begin
      d_key_r <= key_mem[nrd_addr[NA-1:0]];
      d_val_r <= val_mem[nrd_addr[NA-1:0]];
      d_nxt_r <= nxt_mem[nrd_addr[NA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_load) begin
      cur_r        <= head_r;
      prev_valid_r <= 1'b0;
    end else if (cmd.walk_adv) begin
      cur_r        <= d_nxt_r;
      prev_r       <= cur_r;
      prev_valid_r <= 1'b1;
      p_key_r      <= d_key_r;
      p_val_r      <= d_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rem_hit) stk_mem[sp_r[NA-1:0]] <= cur_r[NA-1:0];
    stk_top_r <= stk_mem[NA'(sp_r - 1'b1)];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.load && action_t'(in_action) == ACT_CLR) count_nxt = '0;
    else if (cmd.put_ins) count_nxt = count_r + 1'b1;
    else if (cmd.rem_hit) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      fresh_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load && action_t'(in_action) == ACT_CLR) begin
        sp_r    <= '0;
        fresh_r <= '0;
      end else if (cmd.put_ins) begin
        if (sp_r != '0) sp_r <= sp_r - 1'b1;
        else fresh_r <= fresh_r + 1'b1;
      end else if (cmd.rem_hit) begin
        sp_r <= sp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status         <= cmd.res_status;
      out_found          <= cmd.res_found;
      out_value_head_out <= cmd.res_value ? d_val_r[VW-1:VT_W] : '0;
      out_value_tail_out <= cmd.res_value ? d_val_r[VT_W-1:0] : '0;
      out_entry_count    <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign sts.act        = act_r;
  assign sts.mod_last   = (mc_r == MC_LAST);
  assign sts.head_nil   = (head_r == NIL);
  assign sts.key_match  = (d_key_r == key_r);
  assign sts.next_nil   = (d_nxt_r == NIL);
  assign sts.pool_full  = (count_r == NIL);
  assign sts.sweep_last = (sweep_r == BLAST);
  assign sts.out_busy   = out_valid_r && !out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NIL)
    else $error("entry count above pool size");
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NIL && sp_r <= fresh_r)
    else $error("free stack deeper than allocated nodes");
  a_count_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == fresh_r - sp_r)
    else $error("entry count disagrees with node allocation");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.put_upd, cmd.put_ins, cmd.rem_hit, cmd.sweep_wr}) <= 1)
    else $error("conflicting table updates");

endmodule

// ===== rtl/chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table
// Key-value table with separate chaining over a fixed node pool.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    action, key_in, value_head/tail
//   out_     output     out_valid / out_ready  status, found, value, count
//
// Put, get, remove: accept, bucket hash (reciprocal
// multiply, then remainder), bucket read and head load, a check of each
// chain node visited, then finish.
// Clear: accept, a write of every bucket to empty, then finish.
// After reset every bucket is swept to empty while in_ready is low.
// A held result stalls only the finish of the next transaction.
// ----------------------------------------------------------------------------
module chained_hash_table #(
  parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
  parameter int NODES   = cht_pkg::NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [cht_pkg::KEY_W-1:0]       in_key_in,
  input  logic [cht_pkg::VH_W-1:0]        in_value_head,
  input  logic [cht_pkg::VT_W-1:0]        in_value_tail,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic                            out_found,
  output logic [cht_pkg::VH_W-1:0]        out_value_head_out,
  output logic [cht_pkg::VT_W-1:0]        out_value_tail_out,
  output logic [cht_pkg::CNT_OUT_W-1:0]   out_entry_count
);
  import cht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cht_dp #(
    .BUCKETS (BUCKETS),
    .NODES   (NODES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_action),
    .in_key_in          (in_key_in),
    .in_value_head      (in_value_head),
    .in_value_tail      (in_value_tail),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_value_head_out (out_value_head_out),
    .out_value_tail_out (out_value_tail_out),
    .out_entry_count    (out_entry_count),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
